// File: hw/rtl/crpr_pkg.sv
// Shared types and constants for the chain packet receive relay.
package crpr_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS = 1'd1;

  localparam logic [7:0] MAGIC_RST = 8'h42;
  localparam logic [7:0] BYPASS_RST = 8'h03;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_TUSER_W = 2;

  // One classified input byte: what the back end must emit for it.
  typedef struct packed {
    logic        hdr3;      // magic, hop and opcode go downstream as three beats
    logic        to_down;   // one downstream beat
    logic        to_local;  // one local beat (after the downstream one)
    logic [7:0]  magic;
    logic [7:0]  hop;
    logic [7:0]  data;
    logic [7:0]  opcode;
    logic [15:0] flen;
    logic        payload;
    logic [15:0] index;
    logic        last;
  } job_t;

  // One result beat.
  typedef struct packed {
    logic        dest;
    logic [7:0]  data;
    logic [7:0]  opcode;
    logic [15:0] flen;
    logic        payload;
    logic [15:0] index;
    logic        last;
  } beat_t;

endpackage

// File: hw/rtl/crpr_front.sv
// Front end: header parser that classifies received bytes into jobs for the back end.
module crpr_front import crpr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic [7:0]            in_byte_i,
  output logic                  in_ready_o,
  input  logic                  q_full_i,
  output logic                  push_o,
  output job_t                  job_o
);

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_HOP   = 3'd1,
    PH_OP    = 3'd2,
    PH_LENHI = 3'd3,
    PH_LENLO = 3'd4,
    PH_DATA  = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  magic_q, bypass_q;
  logic [7:0]  hop_q, hop_d;
  logic [7:0]  op_q, op_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic        relay_q, relay_d;

  logic        accept;
  logic        is_local;
  logic        relay_new;
  logic        fin;
  logic        zero_len;
  logic [15:0] len_full;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_local   = (hop_q == 8'd0);
  assign relay_new  = !is_local || (in_byte_i == bypass_q);
  assign len_full   = {len_q[15:8], in_byte_i};
  assign zero_len   = (len_full == 16'd0);
  assign fin        = (cnt_q == (len_q - 16'd1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q  <= MAGIC_RST;
      bypass_q <= BYPASS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAGIC:  magic_q  <= cfg_data_i;
        CFG_BYPASS: bypass_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    hop_d   = hop_q;
    op_d    = op_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    relay_d = relay_q;
    push_o  = 1'b0;
    job_o   = '0;
    job_o.magic  = magic_q;
    job_o.opcode = op_q;
    job_o.data   = in_byte_i;
    if (accept) begin
      case (phase_q)
        PH_HOP: begin
          hop_d   = in_byte_i;
          phase_d = PH_OP;
        end
        PH_OP: begin
          op_d    = in_byte_i;
          relay_d = relay_new;
          // Hold the header until the opcode tells whether the frame is relayed.
          push_o       = relay_new;
          job_o.hdr3   = 1'b1;
          job_o.hop    = is_local ? 8'd0 : (hop_q - 8'd1);
          job_o.opcode = in_byte_i;
          phase_d      = PH_LENHI;
        end
        PH_LENHI: begin
          len_d         = {in_byte_i, 8'd0};
          push_o        = relay_q;
          job_o.to_down = 1'b1;
          phase_d       = PH_LENLO;
        end
        PH_LENLO: begin
          len_d          = len_full;
          cnt_d          = 16'd0;
          push_o         = relay_q || is_local;
          job_o.to_down  = relay_q;
          job_o.to_local = is_local;
          job_o.flen     = len_full;
          job_o.last     = zero_len;
          phase_d        = zero_len ? PH_WAIT : PH_DATA;
        end
        PH_DATA: begin
          push_o         = relay_q || is_local;
          job_o.to_down  = relay_q;
          job_o.to_local = is_local;
          job_o.flen     = len_q;
          job_o.payload  = 1'b1;
          job_o.index    = cnt_q;
          job_o.last     = fin;
          cnt_d          = cnt_q + 16'd1;
          if (fin) begin
            phase_d = PH_WAIT;
          end
        end
        default: begin
          // Drop bytes until a start byte opens a frame.
          if (in_byte_i == magic_q) begin
            phase_d = PH_HOP;
            hop_d   = 8'd0;
            op_d    = 8'd0;
            len_d   = 16'd0;
            cnt_d   = 16'd0;
            relay_d = 1'b0;
          end else begin
            phase_d = PH_WAIT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      hop_q   <= 8'd0;
      op_q    <= 8'd0;
      len_q   <= 16'd0;
      cnt_q   <= 16'd0;
      relay_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hop_q   <= hop_d;
      op_q    <= op_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      relay_q <= relay_d;
    end
  end

endmodule

// File: hw/rtl/crpr_queue.sv
// Job queue between the header parser and the beat emitter.
module crpr_queue import crpr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : (wr_ptr_q + PTR_W'(1));
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : (rd_ptr_q + PTR_W'(1));
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("queue fill count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CNT_FULL) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

// File: hw/rtl/crpr_back.sv
// Back end: expands each queued job into result beats through an output register.
module crpr_back import crpr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  job_valid_i,
  input  job_t  job_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output beat_t out_beat_o
);

  logic [1:0] beat_q, beat_d;
  logic [1:0] n_beats;
  logic       load;
  logic       take;
  logic       last_beat;
  logic       valid_q, valid_d;
  beat_t      beat_out_q;
  beat_t      beat_cur;

  assign n_beats   = job_i.hdr3 ? 2'd3 : ({1'b0, job_i.to_down} + {1'b0, job_i.to_local});
  assign load      = !valid_q || out_ready_i;
  assign take      = job_valid_i && load;
  assign last_beat = (beat_q == (n_beats - 2'd1));
  assign pop_o     = take && last_beat;

  always_comb begin
    beat_cur         = '0;
    beat_cur.opcode  = job_i.opcode;
    beat_cur.flen    = job_i.flen;
    beat_cur.payload = job_i.payload;
    beat_cur.index   = job_i.index;
    beat_cur.last    = job_i.last;
    if (job_i.hdr3) begin
      beat_cur.dest = 1'b0;
      case (beat_q)
        2'd0:    beat_cur.data = job_i.magic;
        2'd1:    beat_cur.data = job_i.hop;
        default: beat_cur.data = job_i.opcode;
      endcase
    end else begin
      // Downstream copy goes first when both sides get the byte.
      beat_cur.dest = !(job_i.to_down && (beat_q == 2'd0));
      beat_cur.data = (beat_cur.dest && !job_i.payload) ? 8'd0 : job_i.data;
    end
  end

  always_comb begin
    beat_d  = beat_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = job_valid_i;
    end
    if (take) begin
      beat_d = last_beat ? 2'd0 : (beat_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q  <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      beat_q  <= beat_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      beat_out_q <= beat_cur;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_out_q;

`ifndef SYNTHESIS
  a_idle_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_valid_i |-> (beat_q == 2'd0))
    else $error("job left the queue with beats pending");

  a_beat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> (beat_q < n_beats))
    else $error("beat count beyond job length");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q)
    else $error("popped job produced no beat");
`endif

endmodule

// File: hw/rtl/chain_packet_receive_relay_core.sv
// Top level of the chain packet receive relay.
// Takes received bytes of daisy-chain frames (magic, hop count, opcode, big-endian
// 16-bit length, payload) one beat per cycle and emits downstream (tuser dest 0) and
// local (dest 1) result beats, one per cycle while m_axis_tready is high, through a
// registered output. A header parser accepts a byte every cycle while the job queue
// (QUEUE_DEPTH entries) has room; the beat emitter drains one result beat per cycle
// while the output is ready, so an opcode byte of a relayed frame yields three
// result beats and a payload byte of a bypass frame two. The output port's one beat
// per cycle sets the sustained rate: one byte per cycle for plain relay or local
// frames, two result beats per byte for bypass payload. A byte's first result beat
// passes through the job queue and then the output register before it is presented.
// Configuration writes take effect at the next edge and are to be made while no
// frame is in flight.
module chain_packet_receive_relay_core import crpr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] out_byte, [15:8] opcode, [31:16] frame_length, [47:32] payload_index
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [0] dest, [1] is_payload
  output logic                   m_axis_tlast
);

  logic  q_full;
  logic  push;
  job_t  push_job;
  logic  pop;
  logic  job_valid;
  job_t  head_job;
  beat_t beat;

  crpr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  crpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (job_valid),
    .head_o     (head_job)
  );

  crpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_beat_o  (beat)
  );

  assign m_axis_tdata = {beat.index, beat.flen, beat.opcode, beat.data};
  assign m_axis_tuser = {beat.payload, beat.dest};
  assign m_axis_tlast = beat.last;

endmodule
